// ----- sv/fmbq_pkg.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// fmbq_pkg: shared types and constants for the front/middle/back queue
// Transaction formats, opcode and status codes, and derived widths.
// ----------------------------------------------------------------------------
package fmbq_pkg;

    // Queue capacity and derived widths
    localparam int DEPTH  = 64;
    localparam int IDX_W  = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W  = $clog2(DEPTH + 1);
    localparam int DATA_W = 32;
    localparam int ECNT_W = 7;

    // Opcodes
    localparam logic [2:0] OP_PUSH_FRONT  = 3'd0;
    localparam logic [2:0] OP_PUSH_MIDDLE = 3'd1;
    localparam logic [2:0] OP_PUSH_BACK   = 3'd2;
    localparam logic [2:0] OP_POP_FRONT   = 3'd3;
    localparam logic [2:0] OP_POP_MIDDLE  = 3'd4;
    localparam logic [2:0] OP_POP_BACK    = 3'd5;

    // Status codes
    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_EMPTY = 2'd1;
    localparam logic [1:0] ST_FULL  = 2'd2;

    // Value returned by a pop on an empty queue
    localparam logic signed [DATA_W-1:0] EMPTY_VALUE = -32'sd1;

    // Request transaction
    typedef struct packed {
        logic [2:0]               opcode;
        logic signed [DATA_W-1:0] push_value;
    } req_t;

    // Response transaction
    typedef struct packed {
        logic signed [DATA_W-1:0] pop_value;
        logic [1:0]               status;
        logic [ECNT_W-1:0]        entry_count;
    } rsp_t;

    // Decoded operation, from the controller to the cell row
    typedef struct packed {
        logic             ins;
        logic             rem;
        logic [IDX_W-1:0] pos;
        logic [1:0]       status;
        logic [CNT_W-1:0] cnt_next;
    } op_ctrl_t;

    // Per-cell controls
    typedef struct packed {
        logic load;
        logic take_left;
        logic take_right;
        logic rd_sel;
    } cell_ctrl_t;

endpackage : fmbq_pkg
`default_nettype wire

// ----- sv/front_middle_back_queue_core.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// front_middle_back_queue_core: queue with push/pop at front, middle, back
// A row of slot cells shifts toward or away from the operation
// point; a decoder picks the point and a response register holds the result.
// ----------------------------------------------------------------------------
// Response: registered, and valid in the cycle after the request is accepted.
// Throughput: one transaction per cycle; the whole cell row shifts in the
//   same cycle, and the request stalls only while a response waits.
// Reset: occupancy and response valid clear at once; slot contents are
//   undefined until written. No clearing pass.
module front_middle_back_queue_core (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           req_valid,
    output logic                req_stall,
    input  wire fmbq_pkg::req_t req,
    output logic                rsp_valid,
    input  wire logic           rsp_stall,
    output fmbq_pkg::rsp_t      rsp
);
    import fmbq_pkg::*;

    logic [CNT_W-1:0]         cnt_reg;
    logic [CNT_W-1:0]         cnt_next;
    logic                     rsp_valid_reg;
    logic                     rsp_valid_next;
    rsp_t                     rsp_reg;
    rsp_t                     rsp_next;
    logic                     req_fire;
    op_ctrl_t                 op;
    cell_ctrl_t               cell_ctrl [DEPTH];
    logic signed [DATA_W-1:0] cell_word [DEPTH];
    logic signed [DATA_W-1:0] cell_rd   [DEPTH];
    logic signed [DATA_W-1:0] rd_bus;

    // Handshake
    assign req_stall = rsp_valid_reg && rsp_stall;
    assign req_fire  = req_valid && !req_stall;

    // Decoder
    fmbq_ctrl u_ctrl (
        .opcode (req.opcode),
        .cnt    (cnt_reg),
        .op     (op)
    );

    // Cell row
    for (genvar i = 0; i < DEPTH; i++)
    begin : g_cell
        logic signed [DATA_W-1:0] left_w;
        logic signed [DATA_W-1:0] right_w;

        always_comb
        begin
            cell_ctrl[i].load       = req_fire && op.ins && (op.pos == IDX_W'(i));
            cell_ctrl[i].take_left  = req_fire && op.ins && (IDX_W'(i) > op.pos);
            cell_ctrl[i].take_right = req_fire && op.rem && (IDX_W'(i) >= op.pos);
            cell_ctrl[i].rd_sel     = op.rem && (op.pos == IDX_W'(i));
        end

        if (i == 0)
        begin : g_first
            assign left_w = req.push_value;
        end
        else
        begin : g_left
            assign left_w = cell_word[i-1];
        end

        if (i == DEPTH - 1)
        begin : g_last
            assign right_w = '0;
        end
        else
        begin : g_right
            assign right_w = cell_word[i+1];
        end

        fmbq_cell u_cell (
            .clk        (clk),
            .ctrl       (cell_ctrl[i]),
            .new_word   (req.push_value),
            .left_word  (left_w),
            .right_word (right_w),
            .word       (cell_word[i]),
            .rd_word    (cell_rd[i])
        );
    end

    // Read bus: only the selected cell drives a nonzero word
    always_comb
    begin
        rd_bus = '0;
        for (int k = 0; k < DEPTH; k++)
        begin
            rd_bus = rd_bus | cell_rd[k];
        end
    end

    // Response and occupancy next state
    always_comb
    begin
        cnt_next       = cnt_reg;
        rsp_next       = rsp_reg;
        rsp_valid_next = rsp_valid_reg && rsp_stall;
        if (req_fire)
        begin
            cnt_next             = op.cnt_next;
            rsp_valid_next       = 1'b1;
            rsp_next.status      = op.status;
            rsp_next.entry_count = ECNT_W'(op.cnt_next);
            if (op.rem)
                rsp_next.pop_value = rd_bus;
            else if (op.status == ST_EMPTY)
                rsp_next.pop_value = EMPTY_VALUE;
            else
                rsp_next.pop_value = '0;
        end
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg       <= '0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            cnt_reg       <= cnt_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    // Response payload, no reset
    always_ff @(posedge clk)
    begin
        rsp_reg <= rsp_next;
    end

    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

`ifndef SYNTHESIS
    // Occupancy never exceeds capacity
    a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg <= CNT_W'(DEPTH))
        else $error("occupancy above capacity");

    // An accepted transaction always produces a response next cycle
    a_rsp_follows: assert property (@(posedge clk) disable iff (!rst_n)
        req_fire |=> rsp_valid_reg)
        else $error("response missing after request");

    // A successful push grows the queue by one
    a_push_grows: assert property (@(posedge clk) disable iff (!rst_n)
        (req_fire && op.ins) |=> (cnt_reg == $past(cnt_reg) + CNT_W'(1)))
        else $error("push did not grow the queue");

    // Occupancy only changes on an accepted transaction
    a_cnt_hold: assert property (@(posedge clk) disable iff (!rst_n)
        !req_fire |=> $stable(cnt_reg))
        else $error("occupancy changed without a request");

    // Empty-pop responses carry the empty marker value
    a_empty_value: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp_valid_reg && rsp_reg.status == ST_EMPTY) |-> (rsp_reg.pop_value == EMPTY_VALUE))
        else $error("empty pop returned wrong value");
`endif

endmodule : front_middle_back_queue_core
`default_nettype wire

// ----- sv/fmbq_cell.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// fmbq_cell: one queue slot
// Holds one word; loads a new word, shifts from a neighbor or holds, and
// drives its word onto the read bus when selected.
// ----------------------------------------------------------------------------
module fmbq_cell (
    input  wire logic                              clk,
    input  wire fmbq_pkg::cell_ctrl_t              ctrl,
    input  wire logic signed [fmbq_pkg::DATA_W-1:0] new_word,
    input  wire logic signed [fmbq_pkg::DATA_W-1:0] left_word,
    input  wire logic signed [fmbq_pkg::DATA_W-1:0] right_word,
    output logic signed [fmbq_pkg::DATA_W-1:0]      word,
    output logic signed [fmbq_pkg::DATA_W-1:0]      rd_word
);
    import fmbq_pkg::*;

    logic signed [DATA_W-1:0] word_reg;
    logic signed [DATA_W-1:0] word_next;

    // Next word: insert, shift toward back, shift toward front, or hold
    always_comb
    begin
        word_next = word_reg;
        if (ctrl.load)
        begin
            word_next = new_word;
        end
        else if (ctrl.take_left)
        begin
            word_next = left_word;
        end
        else if (ctrl.take_right)
        begin
            word_next = right_word;
        end
    end

    // Payload storage, no reset
    always_ff @(posedge clk)
    begin
        word_reg <= word_next;
    end

    assign word    = word_reg;
    assign rd_word = ctrl.rd_sel ? word_reg : '0;

endmodule : fmbq_cell
`default_nettype wire

// ----- sv/fmbq_ctrl.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// fmbq_ctrl: operation decoder
// Turns opcode and occupancy into insert/remove position, status and the
// next occupancy.
// ----------------------------------------------------------------------------
module fmbq_ctrl (
    input  wire logic [2:0]                 opcode,
    input  wire logic [fmbq_pkg::CNT_W-1:0] cnt,
    output fmbq_pkg::op_ctrl_t              op
);
    import fmbq_pkg::*;

    logic             full;
    logic             empty;
    logic [CNT_W-1:0] cnt_m1;

    assign full   = (cnt == CNT_W'(DEPTH));
    assign empty  = (cnt == '0);
    assign cnt_m1 = cnt - CNT_W'(1);

    // Decode
    always_comb
    begin
        op          = '0;
        op.status   = ST_OK;
        op.cnt_next = cnt;
        unique case (opcode) inside
            OP_PUSH_FRONT, OP_PUSH_MIDDLE, OP_PUSH_BACK:
            begin
                if (full)
                begin
                    op.status = ST_FULL;
                end
                else
                begin
                    op.ins      = 1'b1;
                    op.cnt_next = cnt + CNT_W'(1);
                    if (opcode == OP_PUSH_FRONT)
                        op.pos = '0;
                    else if (opcode == OP_PUSH_MIDDLE)
                        op.pos = IDX_W'(cnt >> 1);
                    else
                        op.pos = IDX_W'(cnt);
                end
            end
            OP_POP_FRONT, OP_POP_MIDDLE, OP_POP_BACK:
            begin
                if (empty)
                begin
                    op.status = ST_EMPTY;
                end
                else
                begin
                    op.rem      = 1'b1;
                    op.cnt_next = cnt_m1;
                    if (opcode == OP_POP_FRONT)
                        op.pos = '0;
                    else if (opcode == OP_POP_MIDDLE)
                        op.pos = IDX_W'(cnt_m1 >> 1);
                    else
                        op.pos = IDX_W'(cnt_m1);
                end
            end
            default:
            begin
                // unused opcodes leave the queue alone
                op.status = ST_OK;
            end
        endcase
    end

endmodule : fmbq_ctrl
`default_nettype wire

// ----- verif/testbench.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench: self-checking bench for front_middle_back_queue_core
// Drives push/pop requests at front, middle and back, tracks the queue in a
// local copy, and compares each response field by field. Runs directed
// corner cases, then random fill/drain traffic under several stall patterns.
// ----------------------------------------------------------------------------
module testbench;
    import fmbq_pkg::*;

    // Opcodes that the block decodes as no operation
    localparam logic [2:0] OP_UNUSED_6 = 3'd6;
    localparam logic [2:0] OP_UNUSED_7 = 3'd7;

    // Segment styles for random traffic
    typedef enum int {FILL_MODE, DRAIN_MODE, MIXED_MODE} traffic_mode_t;

    logic clk       = 1'b0;
    logic rst_n     = 1'b0;
    logic req_valid = 1'b0;
    logic rsp_stall = 1'b0;
    req_t req       = '0;
    logic req_stall;
    logic rsp_valid;
    rsp_t rsp;

    // Requests waiting to be driven, and responses still owed by the block
    req_t request_fifo[$];
    rsp_t expected_rsp[$];

    // Local copy of the queue contents, front at index 0
    logic signed [DATA_W-1:0] shadow_queue[$];

    bit          req_taken      = 1'b0;
    int unsigned send_idle_pct  = 0;
    int unsigned recv_stall_pct = 0;
    int unsigned hold_left      = 0;
    int unsigned mismatch_count = 0;
    int unsigned n_accepted     = 0;
    int unsigned n_full_drops   = 0;
    int unsigned n_empty_pops   = 0;
    int unsigned n_unused       = 0;
    int unsigned peak_fill      = 0;

    front_middle_back_queue_core dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .req       (req),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .rsp       (rsp)
    );

    // Clock
    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Apply one request to the shadow queue and return the response it owes
    function automatic rsp_t apply_request(req_t r);
        rsp_t res;
        int   slot;
        res = '{pop_value: '0, status: ST_OK, entry_count: '0};
        case (r.opcode) inside
            OP_PUSH_FRONT, OP_PUSH_MIDDLE, OP_PUSH_BACK:
            begin
                if (shadow_queue.size() >= DEPTH)
                begin
                    res.status = ST_FULL;
                    n_full_drops++;
                end
                else
                begin
                    if (r.opcode == OP_PUSH_FRONT)
                        slot = 0;
                    else if (r.opcode == OP_PUSH_MIDDLE)
                        slot = shadow_queue.size() / 2;
                    else
                        slot = shadow_queue.size();
                    shadow_queue.insert(slot, r.push_value);
                end
            end
            OP_POP_FRONT, OP_POP_MIDDLE, OP_POP_BACK:
            begin
                if (shadow_queue.size() == 0)
                begin
                    res.pop_value = EMPTY_VALUE;
                    res.status    = ST_EMPTY;
                    n_empty_pops++;
                end
                else
                begin
                    if (r.opcode == OP_POP_FRONT)
                        slot = 0;
                    else if (r.opcode == OP_POP_MIDDLE)
                        slot = (shadow_queue.size() - 1) / 2;
                    else
                        slot = shadow_queue.size() - 1;
                    res.pop_value = shadow_queue[slot];
                    shadow_queue.delete(slot);
                end
            end
            default:
                n_unused++;
        endcase
        if (shadow_queue.size() > peak_fill)
            peak_fill = shadow_queue.size();
        res.entry_count = ECNT_W'(shadow_queue.size());
        return res;
    endfunction

    // Monitor: check responses, then record the request accepted at this edge
    always @(posedge clk)
    begin
        rsp_t want;
        req_taken = rst_n && req_valid && !req_stall;
        if (rst_n && rsp_valid && !rsp_stall)
        begin
            if (expected_rsp.size() == 0)
            begin
                $display("%0t: response with none pending: pop_value %0d status %0d count %0d",
                         $time, rsp.pop_value, rsp.status, rsp.entry_count);
                mismatch_count++;
            end
            else
            begin
                want = expected_rsp.pop_front();
                if (rsp.pop_value !== want.pop_value)
                begin
                    $display("%0t: pop_value mismatch: expected %0d, actual %0d",
                             $time, want.pop_value, rsp.pop_value);
                    mismatch_count++;
                end
                if (rsp.status !== want.status)
                begin
                    $display("%0t: status mismatch: expected %0d, actual %0d",
                             $time, want.status, rsp.status);
                    mismatch_count++;
                end
                if (rsp.entry_count !== want.entry_count)
                begin
                    $display("%0t: entry_count mismatch: expected %0d, actual %0d",
                             $time, want.entry_count, rsp.entry_count);
                    mismatch_count++;
                end
            end
        end
        if (req_taken)
        begin
            expected_rsp.push_back(apply_request(req));
            n_accepted++;
        end
    end

    // Driver: present the next request once the current one is taken
    always @(negedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            req_valid <= 1'b0;
            req       <= '0;
        end
        else if (!req_valid || req_taken)
        begin
            if (request_fifo.size() != 0 && $urandom_range(99) >= send_idle_pct)
            begin
                req       <= request_fifo.pop_front();
                req_valid <= 1'b1;
            end
            else
            begin
                req_valid <= 1'b0;
            end
        end
    end

    // Receiver: random stalls, or a long hold-off when one is requested
    always @(negedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rsp_stall <= 1'b0;
        end
        else if (hold_left != 0)
        begin
            rsp_stall <= 1'b1;
            hold_left = hold_left - 1;
        end
        else
        begin
            rsp_stall <= ($urandom_range(99) < recv_stall_pct);
        end
    end

    task automatic add_request(logic [2:0] op, logic signed [DATA_W-1:0] value);
        request_fifo.push_back('{opcode: op, push_value: value});
    endtask

    // Mostly random words, with the extremes and small values mixed in
    function automatic logic signed [DATA_W-1:0] pick_value();
        case ($urandom_range(9))
            0:       return 32'sh7FFF_FFFF;
            1:       return 32'sh8000_0000;
            2:       return -32'sd1;
            3:       return 32'sd0;
            default: return $urandom();
        endcase
    endfunction

    // Random traffic in segments that lean toward filling, draining or neither
    task automatic add_random_traffic(int unsigned total);
        traffic_mode_t mode;
        int unsigned   seg_len;
        int unsigned   push_pct;
        int unsigned   roll;
        while (total != 0)
        begin
            mode     = traffic_mode_t'($urandom_range(2));
            seg_len  = $urandom_range(20, 70);
            push_pct = (mode == FILL_MODE) ? 85 : (mode == DRAIN_MODE) ? 15 : 50;
            if (seg_len > total)
                seg_len = total;
            total -= seg_len;
            repeat (seg_len)
            begin
                roll = $urandom_range(99);
                if (roll < 3)
                    add_request($urandom_range(1) ? OP_UNUSED_6 : OP_UNUSED_7, pick_value());
                else if ($urandom_range(99) < push_pct)
                    add_request(3'($urandom_range(OP_PUSH_BACK)), pick_value());
                else
                    add_request(3'($urandom_range(OP_POP_BACK, OP_POP_FRONT)), pick_value());
            end
        end
    endtask

    // Hold the sender until every request is out and every response is back
    task automatic wait_drained();
        @(posedge clk);
        #1;
        while (request_fifo.size() != 0 || req_valid || expected_rsp.size() != 0)
        begin
            @(posedge clk);
            #1;
        end
    endtask

    task automatic set_idling(int unsigned send_pct, int unsigned recv_pct);
        send_idle_pct  = send_pct;
        recv_stall_pct = recv_pct;
    endtask

    // Stimulus sequence
    initial
    begin
        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Directed: empty pops, extremes, every opcode, return to empty
        set_idling(0, 0);
        add_request(OP_POP_FRONT, 32'sd5);
        add_request(OP_POP_MIDDLE, 32'sd6);
        add_request(OP_POP_BACK, 32'sd7);
        add_request(OP_PUSH_FRONT, 32'sh7FFF_FFFF);
        add_request(OP_PUSH_BACK, 32'sh8000_0000);
        add_request(OP_PUSH_MIDDLE, 32'sd0);
        add_request(OP_PUSH_MIDDLE, -32'sd1);
        add_request(OP_PUSH_FRONT, 32'sh5555_5555);
        add_request(OP_PUSH_BACK, 32'shAAAA_AAAA);
        add_request(OP_PUSH_MIDDLE, 32'sd12345);
        add_request(OP_UNUSED_6, 32'sh1234_5678);
        add_request(OP_UNUSED_7, -32'sd1);
        add_request(OP_POP_MIDDLE, 32'sd0);
        add_request(OP_POP_FRONT, 32'sd0);
        add_request(OP_POP_BACK, 32'sd0);
        add_request(OP_POP_MIDDLE, 32'sd0);
        add_request(OP_PUSH_BACK, 32'sd1);
        add_request(OP_PUSH_BACK, 32'sd2);
        add_request(OP_POP_MIDDLE, 32'sd0);
        add_request(OP_POP_MIDDLE, 32'sd0);
        add_request(OP_POP_BACK, 32'sd0);
        add_request(OP_POP_FRONT, 32'sd0);
        add_request(OP_POP_FRONT, 32'sd0);
        add_request(OP_POP_MIDDLE, 32'sd0);
        wait_drained();

        // Back to back, no idling
        add_random_traffic(200);
        wait_drained();

        // Receiver holds off and so stalls the sender, then pushes fill past capacity
        hold_left = 300;
        repeat (72)
            add_request(3'($urandom_range(OP_PUSH_BACK)), pick_value());
        repeat (20)
            add_request(3'($urandom_range(OP_POP_BACK, OP_POP_FRONT)), pick_value());
        wait_drained();

        // Sparse sender
        set_idling(75, 0);
        add_random_traffic(180);
        wait_drained();

        // Slow receiver
        set_idling(0, 75);
        add_random_traffic(180);
        wait_drained();

        // Light idling on both sides
        set_idling(16, 16);
        add_random_traffic(200);
        wait_drained();

        set_idling(0, 0);
        repeat (5) @(posedge clk);
        $display("Covered %0d requests, peak fill %0d of %0d entries.",
                 n_accepted, peak_fill, DEPTH);
        $display("Full-queue drops %0d, empty-queue pops %0d, unused opcodes %0d.",
                 n_full_drops, n_empty_pops, n_unused);
        if (mismatch_count == 0 && expected_rsp.size() == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

    // Watchdog
    initial
    begin
        #3_000_000;
        $display("Timeout with %0d requests queued and %0d responses pending",
                 request_fifo.size(), expected_rsp.size());
        $display("CHECKS FAILED");
        $finish;
    end

endmodule

// ----- files.f -----
sv/fmbq_pkg.sv
sv/fmbq_cell.sv
sv/fmbq_ctrl.sv
sv/front_middle_back_queue_core.sv
verif/testbench.sv
